### hw/rtl/vlw_pkg.sv
// ---------------------------------------------------------------------------
// vlw_pkg: shared types and constants of the voxel line walker
// Coordinate and fixed-point widths, axis codes and the walk descriptor that
// the setup front hands to the walk engine.
// ---------------------------------------------------------------------------
package vlw_pkg;

    // Coordinate width of every voxel field on both channels.
    localparam int COORD_W = 12;

    // Fixed-point scale of one voxel (1024 = 1 << FIX_SHIFT).
    localparam int FIX_SHIFT = 10;
    localparam int FIX_ONE   = 1 << FIX_SHIFT;

    // Numerator of the step given to an axis that does not move.
    localparam logic [31:0] ZERO_DELTA_NUM = 32'h3fff_ffff;

    // Dividend of the minor-axis step: major magnitude times 1024.
    localparam int DIVIDEND_W = COORD_W + FIX_SHIFT;

    // A step holds either a quotient (22 bits) or the no-motion step, which
    // needs 26 bits at the smallest map side.
    localparam int STEP_W = 26;

    // Accumulators: one start value plus at most 63 added steps.
    localparam int ACC_W = 32;

    // Default map and run limits.
    localparam int MAP_SIDE_DEF   = 512;
    localparam int MAP_HEIGHT_DEF = 64;
    localparam int MAX_CUBES_DEF  = 64;

    // Depth of the descriptor queue between setup and walk.
    localparam int QUEUE_DEPTH = 2;

    // Stream widths.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Everything the walk engine needs to run one line.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] start;
        logic [2:0][COORD_W-1:0] target;
        logic [2:0][STEP_W-1:0]  step;
        logic [2:0][STEP_W-1:0]  acc;
        logic [2:0]              neg;
    } walk_desc_t;

endpackage

### hw/rtl/vlw_div.sv
// ---------------------------------------------------------------------------
// vlw_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, for the minor-axis steps.
// ---------------------------------------------------------------------------
module vlw_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [vlw_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [vlw_pkg::COORD_W-1:0]     divisor,
    output logic                            done,
    output logic [vlw_pkg::DIVIDEND_W-1:0]  quotient
);
    import vlw_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DIVIDEND_W-1:0]  quo_reg;
    logic [COORD_W-1:0]     rem_reg;
    logic [COORD_W-1:0]     dvs_reg;

    logic [COORD_W:0]       trial;
    logic                   fits;
    logic [COORD_W:0]       diff;
    logic [COORD_W-1:0]     rem_next;

    // Shift the next dividend bit into the partial remainder and try the divisor.
    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/vlw_front.sv
// ---------------------------------------------------------------------------
// vlw_front: line setup
// Accepts a start/end request, picks the dominant axis, computes the
// fixed-point steps (the two minor ones with the shared divider) and queues a walk descriptor.
// ---------------------------------------------------------------------------
module vlw_front #(
    parameter int MAP_SIDE = vlw_pkg::MAP_SIDE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vlw_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          q_push_valid,
    input  logic                          q_push_ready,
    output vlw_pkg::walk_desc_t           q_push_data
);
    import vlw_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CLASSIFY = 3'd1;
    localparam logic [2:0] ST_START_A  = 3'd2;
    localparam logic [2:0] ST_WAIT_A   = 3'd3;
    localparam logic [2:0] ST_START_B  = 3'd4;
    localparam logic [2:0] ST_WAIT_B   = 3'd5;
    localparam logic [2:0] ST_PUSH     = 3'd6;

    localparam logic [STEP_W-1:0] ZERO_STEP = STEP_W'(ZERO_DELTA_NUM / MAP_SIDE);

    logic [2:0]              state_reg, state_next;
    logic [2:0][COORD_W-1:0] start_reg;
    logic [2:0][COORD_W-1:0] end_reg;
    logic [2:0][COORD_W-1:0] mag_reg;
    logic [2:0]              neg_reg;
    logic [1:0]              major_reg;
    logic [STEP_W-1:0]       step_a_reg;
    logic [STEP_W-1:0]       step_b_reg;

    logic signed [COORD_W:0] delta [3];
    logic [2:0][COORD_W-1:0] mag;
    logic [1:0]              major;
    logic [1:0]              minor_a;
    logic [COORD_W-1:0]      mag_major;
    logic [COORD_W-1:0]      mag_a;
    logic [COORD_W-1:0]      mag_b;
    logic                    div_start;
    logic                    div_done;
    logic [DIVIDEND_W-1:0]   div_quo;
    logic [STEP_W-1:0]       div_step;
    walk_desc_t              desc;

    // Signed deltas and their magnitudes (at most 4095, so 12 bits hold them).
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            delta[i] = $signed({end_reg[i][COORD_W-1], end_reg[i]})
                     - $signed({start_reg[i][COORD_W-1], start_reg[i]});
            mag[i]   = delta[i][COORD_W] ? COORD_W'(-delta[i]) : COORD_W'(delta[i]);
        end
    end

    // Dominant axis: x wins ties with y and z, y wins ties with z.
    always_comb begin
        if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
            major = AXIS_X;
        end else if (mag[1] >= mag[2]) begin
            major = AXIS_Y;
        end else begin
            major = AXIS_Z;
        end
    end

    // The two minor axes in order: a is the lower axis code, b the higher.
    assign minor_a   = (major_reg == AXIS_X) ? AXIS_Y : AXIS_X;
    assign mag_major = (major_reg == AXIS_X) ? mag_reg[0] :
                       (major_reg == AXIS_Y) ? mag_reg[1] : mag_reg[2];
    assign mag_a     = (major_reg == AXIS_X) ? mag_reg[1] : mag_reg[0];
    assign mag_b     = (major_reg == AXIS_Z) ? mag_reg[1] : mag_reg[2];

    assign div_start = (state_reg == ST_START_A) || (state_reg == ST_START_B);

    vlw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({mag_major, FIX_SHIFT'(0)}),
        .divisor  ((state_reg == ST_START_A) ? mag_a : mag_b),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign div_step = STEP_W'(div_quo);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: state_next = ST_START_A;
            ST_START_A:  state_next = ST_WAIT_A;
            ST_WAIT_A: begin
                if (div_done) begin
                    state_next = ST_START_B;
                end
            end
            ST_START_B:  state_next = ST_WAIT_B;
            ST_WAIT_B: begin
                if (div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (q_push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= s_tdata[i*COORD_W +: COORD_W];
                end_reg[i]   <= s_tdata[(i+3)*COORD_W +: COORD_W];
            end
        end
        if (state_reg == ST_CLASSIFY) begin
            mag_reg   <= mag;
            major_reg <= major;
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= delta[i][COORD_W];
            end
        end
        if (state_reg == ST_WAIT_A && div_done) begin
            step_a_reg <= (mag_a == '0) ? ZERO_STEP : div_step;
        end
        if (state_reg == ST_WAIT_B && div_done) begin
            step_b_reg <= (mag_b == '0) ? ZERO_STEP : div_step;
        end
    end

    // Accumulators start at half a step, rounded up for forward directions.
    always_comb begin
        desc.start  = start_reg;
        desc.target = end_reg;
        desc.neg    = neg_reg;
        for (int i = 0; i < 3; i++) begin
            if (major_reg == 2'(i)) begin
                desc.step[i] = STEP_W'(FIX_ONE);
            end else if (minor_a == 2'(i)) begin
                desc.step[i] = step_a_reg;
            end else begin
                desc.step[i] = step_b_reg;
            end
            desc.acc[i] = neg_reg[i] ? (desc.step[i] >> 1)
                                     : desc.step[i] - (desc.step[i] >> 1);
        end
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign q_push_valid = (state_reg == ST_PUSH);
    assign q_push_data  = desc;

endmodule

### hw/rtl/vlw_queue.sv
// ---------------------------------------------------------------------------
// vlw_queue: descriptor queue
// Small register FIFO between line setup and the walk engine.
// ---------------------------------------------------------------------------
module vlw_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  vlw_pkg::walk_desc_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output vlw_pkg::walk_desc_t pop_data
);
    import vlw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    walk_desc_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/vlw_walk.sv
// ---------------------------------------------------------------------------
// vlw_walk: walk engine
// Steps along one line a voxel per cycle while the output is not stalled and drives the registered output.
// ---------------------------------------------------------------------------
module vlw_walk #(
    parameter int MAP_SIDE   = vlw_pkg::MAP_SIDE_DEF,
    parameter int MAP_HEIGHT = vlw_pkg::MAP_HEIGHT_DEF,
    parameter int MAX_CUBES  = vlw_pkg::MAX_CUBES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_pop_valid,
    output logic                          q_pop_ready,
    input  vlw_pkg::walk_desc_t           q_pop_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vlw_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import vlw_pkg::*;

    localparam int CNT_W = $clog2(MAX_CUBES + 1);
    localparam logic signed [COORD_W:0] SIDE_LIM   = (COORD_W+1)'(MAP_SIDE);
    localparam logic signed [COORD_W:0] HEIGHT_LIM = (COORD_W+1)'(MAP_HEIGHT);
    localparam logic signed [COORD_W:0] ONE_VOXEL  = (COORD_W+1)'(1);

    logic                    active_reg;
    logic [2:0][COORD_W-1:0] cur_reg;
    logic [2:0][COORD_W-1:0] tgt_reg;
    logic [ACC_W-1:0]        acc_reg [3];
    logic [STEP_W-1:0]       step_reg [3];
    logic [2:0]              neg_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    m_tvalid_reg;
    logic                    m_tlast_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic                    load;
    logic                    emit;
    logic [1:0]              sel;
    logic [COORD_W-1:0]      cur_sel;
    logic signed [COORD_W:0] cur_ext;
    logic signed [COORD_W:0] stepped;
    logic signed [COORD_W:0] lim;
    logic                    leaves_map;
    logic                    at_end;
    logic                    cap_hit;
    logic                    last;

    assign q_pop_ready = !active_reg;
    assign load        = q_pop_valid && !active_reg;
    assign emit        = active_reg && (!m_tvalid_reg || m_tready);

    // Smallest accumulator moves; z wins every tie, x only when strictly below y.
    always_comb begin
        if (acc_reg[2] <= acc_reg[0] && acc_reg[2] <= acc_reg[1]) begin
            sel = AXIS_Z;
        end else if (acc_reg[0] < acc_reg[1]) begin
            sel = AXIS_X;
        end else begin
            sel = AXIS_Y;
        end
    end

    assign cur_sel    = cur_reg[sel];
    assign cur_ext    = $signed({cur_sel[COORD_W-1], cur_sel});
    assign stepped    = neg_reg[sel] ? cur_ext - ONE_VOXEL : cur_ext + ONE_VOXEL;
    assign lim        = (sel == AXIS_Z) ? HEIGHT_LIM : SIDE_LIM;
    assign leaves_map = stepped[COORD_W] || (stepped >= lim);
    assign at_end     = (cur_reg == tgt_reg);
    assign cap_hit    = (count_reg == CNT_W'(MAX_CUBES - 1));
    assign last       = cap_hit || at_end || leaves_map;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                active_reg <= 1'b1;
            end else if (emit && last) begin
                active_reg <= 1'b0;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg   <= q_pop_data.start;
            tgt_reg   <= q_pop_data.target;
            neg_reg   <= q_pop_data.neg;
            count_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                acc_reg[i]  <= ACC_W'(q_pop_data.acc[i]);
                step_reg[i] <= q_pop_data.step[i];
            end
        end else if (emit && !last) begin
            cur_reg[sel] <= stepped[COORD_W-1:0];
            acc_reg[sel] <= acc_reg[sel] + ACC_W'(step_reg[sel]);
            count_reg    <= count_reg + 1'b1;
        end
        if (emit) begin
            m_tdata_reg <= {(M_TDATA_W - 3*COORD_W)'(0), cur_reg[2], cur_reg[1], cur_reg[0]};
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The voxel count of a running walk stays below the cap.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (count_reg < CNT_W'(MAX_CUBES)))
        else $error("walk count passed the cap");

    // The voxel flagged last ends the walk.
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last) |=> !active_reg)
        else $error("walk still running after its last voxel");

    // A new descriptor starts a fresh walk with a cleared count.
    a_load_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (active_reg && count_reg == '0))
        else $error("walk did not start cleanly");

endmodule

### hw/rtl/voxel_line_walker_core.sv
// ---------------------------------------------------------------------------
// voxel_line_walker_core: 3D voxel line traversal
// Takes a start and an end voxel and streams the voxels of the line between
// them in order, flagging the last one.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  tdata (lowest bit up)                         tlast
//  s_*       in         start_x, start_y, start_z, end_x, end_y, end_z  -
//  m_*       out        voxel_x, voxel_y, voxel_z, 4 zero bits        last_voxel
//
// Setup of one line, after the request is accepted, classifies the deltas,
// runs two passes of the shared one-bit-per-cycle divider for the minor-axis
// steps (each a start, one iteration per quotient bit and a done strobe) and
// hands the descriptor to the queue; the next request is taken once setup is
// back in idle. The walk then emits one voxel per cycle while the output is
// not stalled, up to MAX_CUBES, and loads the next descriptor when idle;
// setup of the next line overlaps the current walk via a two-entry descriptor queue.
// Reset is synchronous and active low; it empties the queue and idles both
// parts. A stalled output holds the walk, and a full queue holds setup.
// ---------------------------------------------------------------------------
module voxel_line_walker_core #(
    parameter int MAP_SIDE   = vlw_pkg::MAP_SIDE_DEF,
    parameter int MAP_HEIGHT = vlw_pkg::MAP_HEIGHT_DEF,
    parameter int MAX_CUBES  = vlw_pkg::MAX_CUBES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Line request.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x [11:0], start_y [23:12], start_z [35:24],
    // end_x [47:36], end_y [59:48], end_z [71:60]
    input  logic [vlw_pkg::S_TDATA_W-1:0] s_tdata,
    // Voxel results.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // voxel_x [11:0], voxel_y [23:12], voxel_z [35:24], zero [39:36]
    output logic [vlw_pkg::M_TDATA_W-1:0] m_tdata,
    // last_voxel
    output logic                          m_tlast
);
    import vlw_pkg::*;

    // Descriptor hand-off from setup into the queue.
    logic       push_valid;
    logic       push_ready;
    walk_desc_t push_data;

    // Descriptor hand-off from the queue into the walk engine.
    logic       pop_valid;
    logic       pop_ready;
    walk_desc_t pop_data;

    // Front: accepts a request, finds the dominant axis and computes the
    // fixed-point steps and starting accumulators.
    vlw_front #(
        .MAP_SIDE (MAP_SIDE)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .q_push_valid (push_valid),
        .q_push_ready (push_ready),
        .q_push_data  (push_data)
    );

    // Queue: decouples setup from the walk so each can stall on its own.
    vlw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: walks the line and stops at the end point, the map edge or the cap.
    vlw_walk #(
        .MAP_SIDE   (MAP_SIDE),
        .MAP_HEIGHT (MAP_HEIGHT),
        .MAX_CUBES  (MAX_CUBES)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_pop_valid (pop_valid),
        .q_pop_ready (pop_ready),
        .q_pop_data  (pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for voxel_line_walker_core
// Feeds line requests with bursty pacing, traces each line in a behavioral
// walker of its own and checks every streamed voxel and its last flag in
// order. The receiver stalls on its own pattern and holds off once for a
// long stretch.
// ---------------------------------------------------------------------------
module testbench;
    import vlw_pkg::*;

    localparam int SIDE             = MAP_SIDE_DEF;
    localparam int HEIGHT           = MAP_HEIGHT_DEF;
    localparam int CUBE_CAP         = MAX_CUBES_DEF;
    localparam int RANDOM_LINES     = 190;
    localparam int HOLD_AFTER_LINES = 60;
    localparam int HOLD_CYCLES      = 800;
    localparam int SETTLE_CYCLES    = 200;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int MAX_REPORTS      = 60;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
    } voxel_t;

    typedef struct {
        logic [S_TDATA_W-1:0] bits;
        bit                   drain_first;  // hold the request until all voxels are back
    } line_req_t;

    typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PATTERN} rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    line_req_t line_q[$];
    voxel_t    voxel_q[$];

    int total_lines  = 0;
    int lines_sent   = 0;
    int voxels_seen  = 0;
    int mismatches   = 0;
    int cycle_count  = 0;
    int ended_target = 0;
    int ended_edge   = 0;
    int ended_cap    = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int mode_left    = 0;
    int rx_tick      = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    voxel_line_walker_core #(
        .MAP_SIDE   (SIDE),
        .MAP_HEIGHT (HEIGHT),
        .MAX_CUBES  (CUBE_CAP)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("%0t MISMATCH %s", $time, what);
        mismatches++;
    endtask

    // Walks one line the way the block should and queues the voxels it emits.
    task automatic trace_line(input logic [S_TDATA_W-1:0] bits);
        int     cur[3];
        int     tgt[3];
        int     span[3];
        bit     neg[3];
        longint step[3];
        longint acc[3];
        int     major;
        int     ax;
        int     n;
        bit     done;
        voxel_t v;

        for (int i = 0; i < 3; i++) begin
            cur[i]  = $signed(bits[COORD_W*i +: COORD_W]);
            tgt[i]  = $signed(bits[COORD_W*(i+3) +: COORD_W]);
            span[i] = tgt[i] - cur[i];
            neg[i]  = span[i] < 0;
            if (neg[i])
                span[i] = -span[i];
        end

        // Dominant axis: x wins ties with y and z, y wins ties with z.
        if (span[AXIS_X] >= span[AXIS_Y] && span[AXIS_X] >= span[AXIS_Z])
            major = AXIS_X;
        else if (span[AXIS_Y] >= span[AXIS_Z])
            major = AXIS_Y;
        else
            major = AXIS_Z;

        for (int i = 0; i < 3; i++) begin
            if (i == major) begin
                step[i] = FIX_ONE;
                acc[i]  = FIX_ONE / 2;
            end else begin
                if (span[i] == 0)
                    step[i] = longint'(ZERO_DELTA_NUM) / SIDE;
                else
                    step[i] = (longint'(span[major]) * FIX_ONE) / span[i];
                acc[i] = step[i] / 2;
            end
            if (!neg[i])
                acc[i] = step[i] - acc[i];
        end

        n    = 0;
        done = 1'b0;
        while (!done) begin
            v.x = COORD_W'(cur[AXIS_X]);
            v.y = COORD_W'(cur[AXIS_Y]);
            v.z = COORD_W'(cur[AXIS_Z]);
            n++;
            if (n >= CUBE_CAP) begin
                done = 1'b1;
                ended_cap++;
            end else if (cur[AXIS_X] == tgt[AXIS_X] && cur[AXIS_Y] == tgt[AXIS_Y] &&
                         cur[AXIS_Z] == tgt[AXIS_Z]) begin
                done = 1'b1;
                ended_target++;
            end else begin
                // Smallest accumulator moves; z takes every tie.
                if (acc[AXIS_Z] <= acc[AXIS_X] && acc[AXIS_Z] <= acc[AXIS_Y])
                    ax = AXIS_Z;
                else if (acc[AXIS_X] < acc[AXIS_Y])
                    ax = AXIS_X;
                else
                    ax = AXIS_Y;
                cur[ax] += neg[ax] ? -1 : 1;
                if (cur[ax] < 0 || cur[ax] >= ((ax == AXIS_Z) ? HEIGHT : SIDE)) begin
                    // The stepped voxel is off the map, so the voxel being queued is last.
                    done = 1'b1;
                    ended_edge++;
                end else begin
                    acc[ax] += step[ax];
                end
            end
            v.last = done;
            voxel_q.push_back(v);
        end
    endtask

    task automatic add_line(input int sx, sy, sz, ex, ey, ez, input bit drain);
        line_req_t r;
        r.bits = {COORD_W'(ez), COORD_W'(ey), COORD_W'(ex),
                  COORD_W'(sz), COORD_W'(sy), COORD_W'(sx)};
        r.drain_first = drain;
        line_q.push_back(r);
    endtask

    // Mostly short lines inside the map, some long ones that run into the cap,
    // some that start by an edge and cross it, and some raw 12-bit values.
    task automatic add_random_line(input bit drain);
        int sx, sy, sz, ex, ey, ez;
        int pick;
        pick = $urandom_range(0, 99);
        sx = $urandom_range(0, SIDE - 1);
        sy = $urandom_range(0, SIDE - 1);
        sz = $urandom_range(0, HEIGHT - 1);
        if (pick < 55) begin
            ex = sx + int'($urandom_range(0, 60)) - 30;
            ey = sy + int'($urandom_range(0, 60)) - 30;
            ez = sz + int'($urandom_range(0, 40)) - 20;
        end else if (pick < 70) begin
            ex = $urandom_range(0, SIDE - 1);
            ey = $urandom_range(0, SIDE - 1);
            ez = $urandom_range(0, HEIGHT - 1);
        end else if (pick < 85) begin
            sx = int'($urandom_range(0, 4095)) - 2048;
            sy = int'($urandom_range(0, 4095)) - 2048;
            sz = int'($urandom_range(0, 4095)) - 2048;
            ex = int'($urandom_range(0, 4095)) - 2048;
            ey = int'($urandom_range(0, 4095)) - 2048;
            ez = int'($urandom_range(0, 4095)) - 2048;
        end else begin
            sx = $urandom_range(0, 1) ? $urandom_range(0, 5) : SIDE - 1 - $urandom_range(0, 5);
            sy = $urandom_range(0, 1) ? $urandom_range(0, 5) : SIDE - 1 - $urandom_range(0, 5);
            sz = $urandom_range(0, 1) ? $urandom_range(0, 5) : HEIGHT - 1 - $urandom_range(0, 5);
            ex = sx + int'($urandom_range(0, 80)) - 40;
            ey = sy + int'($urandom_range(0, 80)) - 40;
            ez = sz + int'($urandom_range(0, 80)) - 40;
        end
        add_line(sx, sy, sz, ex, ey, ez, drain);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        line_req_t next;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                trace_line(s_tdata);
                lines_sent <= lines_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (line_q.size() != 0 &&
                             !(line_q[0].drain_first && voxel_q.size() != 0)) begin
                    next = line_q.pop_front();
                    s_tdata  <= next.bits;
                    s_tvalid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 8);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches among random stall modes, plus one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && lines_sent >= HOLD_AFTER_LINES) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(40, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
                RX_RARELY: m_tready <= ($urandom_range(0, 9) < 3);
                default:   m_tready <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    // Voxel monitor.
    always @(posedge aclk) begin
        voxel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            voxels_seen++;
            if (voxel_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected voxel (%0d,%0d,%0d) last %b",
                    $signed(m_tdata[COORD_W-1:0]), $signed(m_tdata[2*COORD_W-1:COORD_W]),
                    $signed(m_tdata[3*COORD_W-1:2*COORD_W]), m_tlast));
            end else begin
                want = voxel_q.pop_front();
                if (m_tdata[COORD_W-1:0] !== want.x ||
                    m_tdata[2*COORD_W-1:COORD_W] !== want.y ||
                    m_tdata[3*COORD_W-1:2*COORD_W] !== want.z ||
                    m_tdata[M_TDATA_W-1:3*COORD_W] !== '0 ||
                    m_tlast !== want.last)
                    flag_mismatch($sformatf(
                        "voxel %0d: got (%0d,%0d,%0d) last %b pad %h, want (%0d,%0d,%0d) last %b",
                        voxels_seen, $signed(m_tdata[COORD_W-1:0]),
                        $signed(m_tdata[2*COORD_W-1:COORD_W]),
                        $signed(m_tdata[3*COORD_W-1:2*COORD_W]), m_tlast,
                        m_tdata[M_TDATA_W-1:3*COORD_W],
                        $signed(want.x), $signed(want.y), $signed(want.z), want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout: %0d of %0d lines sent, %0d voxels outstanding",
                     $time, lines_sent, total_lines, voxel_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        // Degenerate lines: start equals end, inside and at both field extremes.
        add_line(0, 0, 0, 0, 0, 0, 1'b0);
        add_line(-2048, -2048, -2048, -2048, -2048, -2048, 1'b0);
        add_line(2047, 2047, 2047, 2047, 2047, 2047, 1'b0);
        // Each axis dominant: x in both directions, y falling, z rising.
        add_line(10, 20, 5, 40, 27, 9, 1'b0);
        add_line(300, 400, 50, 290, 350, 40, 1'b0);
        add_line(100, 100, 0, 103, 98, 63, 1'b0);
        add_line(100, 100, 40, 70, 80, 20, 1'b0);
        // Ties between the magnitudes.
        add_line(0, 0, 0, 20, 20, 0, 1'b0);
        add_line(5, 5, 5, 25, 25, 25, 1'b0);
        add_line(50, 50, 10, 52, 70, 30, 1'b0);
        // Longer than the run cap.
        add_line(0, 0, 0, 511, 300, 63, 1'b0);
        // Walks that leave the map: low x, high z, high y and low z.
        add_line(3, 10, 10, -20, 12, 10, 1'b0);
        add_line(10, 10, 60, 12, 15, 80, 1'b0);
        add_line(200, 505, 30, 205, 530, 31, 1'b0);
        add_line(0, 0, 0, 0, 0, -1, 1'b0);
        // Start already off the map.
        add_line(-5, 10, 10, 10, 10, 10, 1'b0);
        add_line(-2048, 2047, -2048, 2047, -2048, 2047, 1'b0);
        add_line(2047, -2048, 2047, -2048, 2047, -2048, 1'b0);
        // End far outside the map, a single step, and a nearly straight line.
        add_line(256, 256, 32, 2047, -2048, 0, 1'b0);
        add_line(7, 7, 7, 8, 7, 7, 1'b0);
        add_line(0, 0, 0, 60, 1, 1, 1'b0);
        for (int k = 0; k < RANDOM_LINES; k++)
            add_random_line(k == 0 || k == 120);
        total_lines = line_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (lines_sent < total_lines)
            @(posedge aclk);
        while (voxel_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Traced %0d lines into %0d voxels: %0d reached the end point, %0d left the map,",
                 total_lines, voxels_seen, ended_target, ended_edge);
        $display("%0d hit the run cap; receiver held off %0d cycles once, %0d mismatches.",
                 ended_cap, HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
